// ===== src/pfa_pkg.sv =====
// Shared types and constants for the physical page frame allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfa_pkg;

    // Used-map word geometry: 64 page flags per memory word
    localparam int WORD_BITS  = 64;
    localparam int BIT_IDX_W  = 6;

    // Request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_FREE      = 3'd1;
    localparam logic [2:0] ST_BELOW_BASE   = 3'd2;
    localparam logic [2:0] ST_BEYOND_END   = 3'd3;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_ALLOC    = 5'b00100,
        S_ALLOC_WR = 5'b01000,
        S_FREE     = 5'b10000
    } state_t;

    // Find-first-zero result
    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] idx;
    } ffz_res_t;

endpackage

// ===== src/pfa_map_ram.sv =====
// Used-flag map storage: one write port, one read port with registered data.
// Depends on pfa_pkg for the word width.
`timescale 1ns / 1ps

module pfa_map_ram
    import pfa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    // Write the selected word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/pfa_ffz.sv =====
// Find-first-zero over one 64-bit map word, two-level byte search.
// Depends on pfa_pkg for the word geometry and result struct.
`timescale 1ns / 1ps

module pfa_ffz
    import pfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    output ffz_res_t             res
);

    localparam int NBYTES = WORD_BITS / 8;

    logic [NBYTES-1:0] byte_zero;
    logic [2:0]        byte_idx [NBYTES];

    // Locate the lowest clear bit inside each byte
    always_comb
    begin
        for (int j = 0; j < NBYTES; j++)
        begin
            byte_zero[j] = ~&word[j*8 +: 8];
            byte_idx[j]  = 3'd0;
            for (int k = 7; k >= 0; k--)
            begin
                if (!word[j*8 + k])
                begin
                    byte_idx[j] = 3'(k);
                end
            end
        end
    end

    // Pick the lowest byte that holds a clear bit
    always_comb
    begin
        res.found = |byte_zero;
        res.idx   = '0;
        for (int j = NBYTES - 1; j >= 0; j--)
        begin
            if (byte_zero[j])
            begin
                res.idx = {3'(j), byte_idx[j]};
            end
        end
    end

endmodule

// ===== src/physical_page_frame_allocator.sv =====
// Physical page frame allocator: command sequencer over a word-wide used map.
// Depends on pfa_pkg, pfa_map_ram and pfa_ffz.
// Allocate scans map words from the lowest until one has a clear flag, then sets it; a full map
// returns ST_NO_FREE. Free checks the range, then reads and clears the flag; clear sweeps all words.
// Throughput: one request at a time, set by the single map read port scanning a word a cycle.
// Reset clears the map with a sweep over every word, busy high meanwhile.
// done pulses for one cycle per request; the receiver cannot stall it.
`timescale 1ns / 1ps

module physical_page_frame_allocator
    import pfa_pkg::*;
#(
    parameter int              NUM_PAGES    = 4096,
    parameter longint unsigned BASE_ADDRESS = 1048576,
    parameter int              PAGE_SHIFT   = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    output logic        busy,
    output logic        done,
    output logic [31:0] page_address,
    output logic [2:0]  status
);

    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WW-1:0]        LAST_WORD = WW'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [31:0]          BASE32    = 32'(BASE_ADDRESS);
    localparam logic [33:0]          END_ADDR  =
        34'(BASE_ADDRESS) + (34'(NUM_PAGES) << PAGE_SHIFT);

    state_t               state_reg, state_next;
    logic [WW-1:0]        idx_reg, idx_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 report_reg, report_next;
    logic                 done_reg, done_next;
    logic [31:0]          page_address_reg, page_address_next;
    logic [2:0]           status_reg, status_next;

    logic                 wr_en;
    logic [WW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] scan_word;
    ffz_res_t             ffz_res;
    logic [31:0]          rel_page;
    logic [31:0]          alloc_page;
    logic [WORD_BITS-1:0] bit_mask;

    pfa_map_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (WW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    // Treat flags past the last page as used
    assign scan_word = (idx_reg == LAST_WORD) ? (rd_data | ~LAST_MASK) : rd_data;

    pfa_ffz u_ffz (
        .word (scan_word),
        .res  (ffz_res)
    );

    assign rel_page   = (address - BASE32) >> PAGE_SHIFT;
    assign alloc_page = (32'(idx_reg) << BIT_IDX_W) | 32'(bit_reg);
    assign bit_mask   = WORD_BITS'(1) << bit_reg;

    // Sequence requests over the shared map port and search unit
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        bit_next          = bit_reg;
        word_next         = word_reg;
        report_next       = report_reg;
        done_next         = 1'b0;
        page_address_next = page_address_reg;
        status_next       = status_reg;
        wr_en             = 1'b0;
        wr_addr           = idx_reg;
        wr_data           = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (idx_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                    if (report_reg)
                    begin
                        done_next         = 1'b1;
                        page_address_next = '0;
                        status_next       = ST_OK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_ALLOC:
                        begin
                            idx_next   = '0;
                            state_next = S_ALLOC;
                        end
                        KIND_FREE:
                        begin
                            page_address_next = '0;
                            if (address < BASE32)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BELOW_BASE;
                            end
                            else if ({2'b00, address} >= END_ADDR)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BEYOND_END;
                            end
                            else
                            begin
                                idx_next   = rel_page[WW+BIT_IDX_W-1:BIT_IDX_W];
                                bit_next   = rel_page[BIT_IDX_W-1:0];
                                state_next = S_FREE;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            idx_next    = '0;
                            report_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                            done_next         = 1'b1;
                            page_address_next = '0;
                            status_next       = ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (ffz_res.found)
                begin
                    word_next  = rd_data;
                    bit_next   = ffz_res.idx;
                    state_next = S_ALLOC_WR;
                end
                else if (idx_reg == LAST_WORD)
                begin
                    done_next         = 1'b1;
                    page_address_next = '0;
                    status_next       = ST_NO_FREE;
                    state_next        = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ALLOC_WR:
            begin
                wr_en             = 1'b1;
                wr_data           = word_reg | bit_mask;
                done_next         = 1'b1;
                page_address_next = BASE32 + (alloc_page << PAGE_SHIFT);
                status_next       = ST_OK;
                state_next        = S_IDLE;
            end
            S_FREE:
            begin
                done_next         = 1'b1;
                page_address_next = '0;
                if (rd_data[bit_reg])
                begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data & ~bit_mask;
                    status_next = ST_OK;
                end
                else
                begin
                    status_next = ST_ALREADY_FREE;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state; reset starts a silent clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        bit_reg          <= bit_next;
        word_reg         <= word_next;
        page_address_reg <= page_address_next;
        status_reg       <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;

    // Only allocation success carries an address
    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != ST_OK) |-> (page_address_reg == 32'd0))
        else $error("error result carries a page address");

    // Map writes only come from write-capable states
    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_ALLOC_WR || state_reg == S_FREE || state_reg == S_CLEAR))
        else $error("map write outside a write state");

    // Accepted allocate keeps the block busy next cycle
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (kind == KIND_ALLOC) |=> busy)
        else $error("allocate request did not start a scan");

    // An allocation write state is followed in the next cycle by an OK result
    a_wr_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_WR) |=> done_reg && (status_reg == ST_OK))
        else $error("allocation write without result");

endmodule

// ===== dv/physical_page_frame_allocator_test.sv =====
// Self-checking testbench for physical_page_frame_allocator: directed table, then random
// allocate/free/clear traffic predicted against a local copy of the used-frame map.
// Depends on pfa_pkg and the RTL under src/.
`timescale 1ns / 1ps

module physical_page_frame_allocator_test
    import pfa_pkg::*;
();

    localparam int              FRAME_COUNT   = 4096;
    localparam longint unsigned FRAME_BASE    = 1048576;
    localparam int              FRAME_SHIFT   = 12;
    localparam longint unsigned FRAME_END     = FRAME_BASE
                                                + (longint'(FRAME_COUNT) << FRAME_SHIFT);
    localparam int              FRAME_BYTES   = 1 << FRAME_SHIFT;
    localparam logic [1:0]      KIND_NONE     = 2'd3;
    localparam int              CYCLE_LIMIT   = 3000000;
    localparam int              SETTLE_CYCLES = 80;
    localparam int              DIRECTED_ROWS = 18;

    typedef enum {MIX_TRAFFIC, FILL_MAP, NEAR_FULL} traffic_t;

    typedef struct packed {
        logic [31:0] page_address;
        logic [2:0]  status;
    } frame_result_t;

    // One row of the directed table; typed rows carry a hand-written expectation
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic        typed;
        logic [31:0] page_address;
        logic [2:0]  status;
    } directed_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  kind         = KIND_ALLOC;
    logic [31:0] address      = '0;
    logic        busy;
    logic        done;
    logic [31:0] page_address;
    logic [2:0]  status;

    bit            frame_used [FRAME_COUNT];
    int            used_frames = 0;
    frame_result_t expected_results [$];
    int            mismatch_count = 0;
    int            result_count = 0;
    int            cycle_count = 0;
    bit            gaps_on = 1'b1;

    directed_row_t directed_steps [DIRECTED_ROWS] = '{
        '{KIND_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_0000, ST_OK},
        '{KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'h0010_1000, ST_OK},
        '{KIND_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_BELOW_BASE},
        '{KIND_FREE,  32'h000F_FFFF, 1'b1, 32'h0000_0000, ST_BELOW_BASE},
        '{KIND_FREE,  32'h0110_0000, 1'b1, 32'h0000_0000, ST_BEYOND_END},
        '{KIND_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_BEYOND_END},
        '{KIND_FREE,  32'h010F_FFFF, 1'b1, 32'h0000_0000, ST_ALREADY_FREE},
        '{KIND_FREE,  32'h0010_0FFF, 1'b1, 32'h0000_0000, ST_OK},
        '{KIND_FREE,  32'h0010_0000, 1'b1, 32'h0000_0000, ST_ALREADY_FREE},
        '{KIND_NONE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{KIND_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{KIND_ALLOC, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, ST_OK},
        '{KIND_FREE,  32'h0010_1800, 1'b0, 32'h0000_0000, ST_OK},
        '{KIND_CLEAR, 32'hA5A5_A5A5, 1'b1, 32'h0000_0000, ST_OK},
        '{KIND_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_0000, ST_OK},
        '{KIND_FREE,  32'h0010_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{KIND_NONE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{KIND_FREE,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_BEYOND_END}
    };

    physical_page_frame_allocator #(
        .NUM_PAGES    (FRAME_COUNT),
        .BASE_ADDRESS (FRAME_BASE),
        .PAGE_SHIFT   (FRAME_SHIFT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .address      (address),
        .busy         (busy),
        .done         (done),
        .page_address (page_address),
        .status       (status)
    );

    always #5 clk = ~clk;

    // Apply one request to the local frame map and return the result it should give
    function automatic frame_result_t apply_request(input logic [1:0] req_kind,
                                                    input logic [31:0] req_address);
        frame_result_t   r;
        int              found;
        longint unsigned frame;
        r.page_address = '0;
        r.status       = ST_OK;
        if (req_kind == KIND_ALLOC)
        begin
            found = 0;
            while (found < FRAME_COUNT && frame_used[found])
                found++;
            if (found == FRAME_COUNT)
            begin
                r.status = ST_NO_FREE;
            end
            else
            begin
                frame_used[found] = 1'b1;
                used_frames++;
                r.page_address = 32'(FRAME_BASE + (longint'(found) << FRAME_SHIFT));
            end
        end
        else if (req_kind == KIND_FREE)
        begin
            if (64'(req_address) < FRAME_BASE)
            begin
                r.status = ST_BELOW_BASE;
            end
            else if (64'(req_address) >= FRAME_END)
            begin
                r.status = ST_BEYOND_END;
            end
            else
            begin
                frame = (64'(req_address) - FRAME_BASE) >> FRAME_SHIFT;
                if (frame_used[frame])
                begin
                    frame_used[frame] = 1'b0;
                    used_frames--;
                end
                else
                begin
                    r.status = ST_ALREADY_FREE;
                end
            end
        end
        else if (req_kind == KIND_CLEAR)
        begin
            for (int i = 0; i < FRAME_COUNT; i++)
                frame_used[i] = 1'b0;
            used_frames = 0;
        end
        return r;
    endfunction

    // Address inside some used frame, aligned or not; needs at least one used frame
    function automatic logic [31:0] used_frame_address();
        int frame;
        frame = $urandom_range(0, FRAME_COUNT - 1);
        while (!frame_used[frame])
            frame = (frame + 1) % FRAME_COUNT;
        return 32'(FRAME_BASE + (longint'(frame) << FRAME_SHIFT)
                   + ($urandom_range(0, 1) ? $urandom_range(0, FRAME_BYTES - 1) : 0));
    endfunction

    function automatic logic [31:0] in_range_address();
        return 32'(FRAME_BASE + $urandom_range(0, FRAME_COUNT * FRAME_BYTES - 1));
    endfunction

    // Draw one request; the mix depends on which part of the run we are in
    task automatic pick_request(input traffic_t traffic, output logic [1:0] req_kind,
                                output logic [31:0] req_address);
        int roll;
        roll = $urandom_range(0, 99);
        req_kind    = KIND_FREE;
        req_address = $urandom;
        case (traffic)
            MIX_TRAFFIC:
            begin
                if (roll < 45)
                    req_kind = KIND_ALLOC;
                else if (roll < 78)
                    req_address = used_frames > 0 ? used_frame_address() : in_range_address();
                else if (roll < 88)
                    req_address = $urandom;
                else if (roll < 94)
                    req_address = in_range_address();
                else if (roll < 97)
                    req_kind = KIND_CLEAR;
                else
                    req_kind = KIND_NONE;
            end
            FILL_MAP:
            begin
                if (roll < 90)
                    req_kind = KIND_ALLOC;
                else if (roll < 96 && used_frames > 0)
                    req_address = used_frame_address();
                else
                    req_address = in_range_address();
            end
            default:
            begin
                if (roll < 50)
                    req_kind = KIND_ALLOC;
                else if (roll < 80 && used_frames > 0)
                    req_address = used_frame_address();
                else
                    req_address = 32'(FRAME_END - 1 - $urandom_range(0, FRAME_BYTES - 1));
            end
        endcase
    endtask

    // Idle cycles before the next request: mostly short, now and then long
    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 99) >= 38)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 3);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [1:0] req_kind, input logic [31:0] req_address);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        kind    <= req_kind;
        address <= req_address;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic issue(input logic [1:0] req_kind, input logic [31:0] req_address);
        send_request(req_kind, req_address);
        expected_results.push_back(apply_request(req_kind, req_address));
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: result %0d %s: got %h, want %h", $time, result_count, what, got,
                 want);
        mismatch_count++;
    endtask

    // Check each returned result against the oldest pending one
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("arrived with none pending", page_address, 32'(status));
            end
            else
            begin
                want = expected_results.pop_front();
                if (page_address !== want.page_address)
                    report_mismatch("page_address", page_address, want.page_address);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
            end
            result_count++;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]    req_kind;
        logic [31:0]   req_address;
        frame_result_t predicted;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_steps[i])
        begin
            send_request(directed_steps[i].kind, directed_steps[i].address);
            predicted = apply_request(directed_steps[i].kind, directed_steps[i].address);
            if (directed_steps[i].typed)
            begin
                predicted.page_address = directed_steps[i].page_address;
                predicted.status       = directed_steps[i].status;
            end
            expected_results.push_back(predicted);
        end
        wait_for_results();

        // Mixed traffic, draining now and then
        for (int n = 0; n < 500; n++)
        begin
            pick_request(MIX_TRAFFIC, req_kind, req_address);
            issue(req_kind, req_address);
            if (n % 100 == 99)
                wait_for_results();
        end

        // Grow the map from empty with allocation-heavy traffic, then hit the top frame
        issue(KIND_CLEAR, $urandom);
        for (int n = 0; n < 100; n++)
        begin
            pick_request(FILL_MAP, req_kind, req_address);
            issue(req_kind, req_address);
        end
        for (int n = 0; n < 60; n++)
        begin
            pick_request(NEAR_FULL, req_kind, req_address);
            issue(req_kind, req_address);
        end
        wait_for_results();

        // More mixed traffic, the first stretch with no idle cycles
        for (int n = 0; n < 720; n++)
        begin
            gaps_on = (n >= 300);
            pick_request(MIX_TRAFFIC, req_kind, req_address);
            issue(req_kind, req_address);
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pfa_pkg.sv
src/pfa_map_ram.sv
src/pfa_ffz.sv
src/physical_page_frame_allocator.sv
dv/physical_page_frame_allocator_test.sv
